[sv/vda_pkg.sv]
// Shared types and constants for the vector distance accumulator.
// No dependencies; used by vda_iter_unit and vector_distance_accumulator_top.
`default_nettype none
package vda_pkg;

  localparam logic [2:0] MODE_L2SQ   = 3'd0;
  localparam logic [2:0] MODE_DOT    = 3'd1;
  localparam logic [2:0] MODE_FASTL2 = 3'd2;
  localparam logic [2:0] MODE_COS    = 3'd3;
  localparam logic [2:0] MODE_NORMSQ = 3'd4;
  localparam logic [2:0] MODE_ROOT   = 3'd5;

  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_OVF  = 2'd1;
  localparam logic [1:0] ERR_ZERO = 2'd2;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_THRESH = 2'd1;

  localparam logic [15:0] THRESH_RESET = 16'd168;

  localparam logic [6:0] MUL_STEPS  = 7'd48;
  localparam logic [6:0] DIV_STEPS  = 7'd96;
  localparam logic [6:0] SQRT_STEPS = 7'd36;

  typedef enum logic [1:0] {
    UOP_MUL,
    UOP_DIV,
    UOP_SQRT
  } uop_t;

  typedef struct packed {
    logic start;
    uop_t op;
  } unit_req_t;

endpackage
`default_nettype wire

[sv/vector_distance_accumulator_top.sv]
// Vector distance accumulator: L2 squared, inner product, fast L2, cosine, norms.
// An accepted element request is folded into the registered sum; after the last
// element the result passes through S_FIN and S_OUT into the output register, in
// cosine mode also S_MUL and S_DIV (48-step multiply, 96-step divide), in root mode S_ROOT.
// Throughput: one element per cycle while idle; in_stall holds the channel until the result is registered.
// Reset (rst, synchronous): sum, counters and flags cleared, mode 0, threshold 168.
`default_nettype none
module vector_distance_accumulator_top #(
  parameter int MAX_DIMENSION = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Element request channel.
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] elem_a,
  input  wire logic signed [15:0] elem_b,
  input  wire logic signed [47:0] norm_a,
  input  wire logic signed [47:0] norm_b,
  input  wire logic               last_elem,
  // Result request channel.
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [47:0]      distance,
  output logic [1:0]              error_code,
  // Configuration write channel.
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  localparam int CW = $clog2(MAX_DIMENSION + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIN,
    S_MUL,
    S_DIV,
    S_ROOT,
    S_OUT
  } state_t;

  localparam logic signed [50:0] MAX48_W = 51'sh7FFFFFFFFFFF;
  localparam logic signed [50:0] ONE_Q24 = 51'sd16777216;

  state_t             state;
  logic [2:0]         distance_mode;
  logic [15:0]        zero_threshold;
  logic signed [47:0] accumulator;
  logic               overflow_seen;
  logic [CW-1:0]      elem_count;
  logic [2:0]         mode_q;
  logic signed [47:0] na_q;
  logic signed [47:0] nb_q;
  logic signed [47:0] res_dist;
  logic [1:0]         res_err;

  vda_pkg::unit_req_t unit_req;
  logic [95:0]        unit_a;
  logic [95:0]        unit_b;
  logic               unit_busy;
  logic [95:0]        unit_res;

  // Every element is folded in through one 17x17 multiplier; the operands
  // depend on the mode in force for that element.
  logic [2:0]         mode_eff;
  logic signed [16:0] mx;
  logic signed [16:0] my;
  logic signed [33:0] term;
  logic signed [48:0] acc_sum;
  logic signed [47:0] acc_sat;
  logic               acc_ovf;
  logic               in_fire;

  assign in_fire  = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    mode_eff = (distance_mode > vda_pkg::MODE_ROOT) ? vda_pkg::MODE_L2SQ : distance_mode;
    case (mode_eff)
      vda_pkg::MODE_L2SQ: begin
        mx = 17'(elem_a) - 17'(elem_b);
        my = mx;
      end
      vda_pkg::MODE_DOT, vda_pkg::MODE_FASTL2, vda_pkg::MODE_COS: begin
        mx = 17'(elem_a);
        my = 17'(elem_b);
      end
      default: begin
        mx = 17'(elem_a);
        my = 17'(elem_a);
      end
    endcase
    term    = mx * my;
    acc_sum = 49'(accumulator) + 49'(term);
    acc_ovf = acc_sum[48] != acc_sum[47];
    if (!acc_ovf) begin
      acc_sat = acc_sum[47:0];
    end else if (acc_sum[48]) begin
      acc_sat = {1'b1, 47'd0};
    end else begin
      acc_sat = {1'b0, {47{1'b1}}};
    end
  end

  // Final-step arithmetic on the values latched at the last element.
  logic [47:0]        mag_na;
  logic [47:0]        mag_nb;
  logic [47:0]        mag_acc;
  logic               norms_small;
  logic               neg_ratio;
  logic signed [50:0] fast_sum;
  logic               fast_ovf;
  logic signed [47:0] fast_sat;
  logic [48:0]        qc;
  logic signed [50:0] cos_sum;
  logic               cos_ovf;
  logic signed [47:0] cos_sat;
  logic [47:0]        root_s;

  always_comb begin
    mag_na  = na_q[47] ? 48'(-na_q) : na_q;
    mag_nb  = nb_q[47] ? 48'(-nb_q) : nb_q;
    mag_acc = accumulator[47] ? 48'(-accumulator) : accumulator;
    norms_small = (mag_na < {32'd0, zero_threshold}) || (mag_nb < {32'd0, zero_threshold});
    neg_ratio = accumulator[47] ^ na_q[47] ^ nb_q[47];

    fast_sum = 51'(na_q) + 51'(nb_q) - (51'(accumulator) <<< 1);
    fast_ovf = (fast_sum > MAX48_W) || (fast_sum < -MAX48_W - 51'sd1);
    fast_sat = fast_ovf ? (fast_sum[50] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}})
                        : fast_sum[47:0];

    // Clamp the quotient to one in Q48.
    qc = (unit_res[95:49] != '0 || unit_res[48:0] > {1'b1, 48'd0}) ? {1'b1, 48'd0}
                                                                     : unit_res[48:0];
    cos_sum = neg_ratio ? ONE_Q24 + 51'(qc) : ONE_Q24 - 51'(qc);
    cos_ovf = (cos_sum > MAX48_W) || (cos_sum < -MAX48_W - 51'sd1);
    cos_sat = cos_ovf ? (cos_sum[50] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}})
                      : cos_sum[47:0];

    root_s = accumulator[47] ? 48'd0 : accumulator;

    unit_req.start = 1'b0;
    unit_req.op    = vda_pkg::UOP_MUL;
    unit_a         = {48'd0, mag_na};
    unit_b         = {48'd0, mag_nb};
    if (state == S_FIN && mode_q == vda_pkg::MODE_COS && !norms_small) begin
      unit_req.start = 1'b1;
    end else if (state == S_FIN && mode_q == vda_pkg::MODE_ROOT) begin
      unit_req.start = 1'b1;
      unit_req.op    = vda_pkg::UOP_SQRT;
      unit_a         = {24'd0, root_s, 24'd0};
    end else if (state == S_MUL && !unit_busy && unit_res != '0) begin
      unit_req.start = 1'b1;
      unit_req.op    = vda_pkg::UOP_DIV;
      unit_a         = {mag_acc, 48'd0};
      unit_b         = unit_res;
    end
  end

  vda_iter_unit u_iter (
    .clk    (clk),
    .rst    (rst),
    .req    (unit_req),
    .arg_a  (unit_a),
    .arg_b  (unit_b),
    .busy   (unit_busy),
    .result (unit_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      distance_mode  <= vda_pkg::MODE_L2SQ;
      zero_threshold <= vda_pkg::THRESH_RESET;
      accumulator    <= '0;
      overflow_seen  <= 1'b0;
      elem_count     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vda_pkg::REG_MODE:   distance_mode  <= cfg_data[2:0];
          vda_pkg::REG_THRESH: zero_threshold <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (elem_count < CW'(MAX_DIMENSION)) begin
              accumulator <= acc_sat;
              if (acc_ovf) begin
                overflow_seen <= 1'b1;
              end
              elem_count <= elem_count + 1'b1;
            end else begin
              overflow_seen <= 1'b1;
            end
            if (last_elem) begin
              mode_q <= mode_eff;
              na_q   <= norm_a;
              nb_q   <= norm_b;
              state  <= S_FIN;
            end
          end
        end
        S_FIN: begin
          res_err  <= overflow_seen ? vda_pkg::ERR_OVF : vda_pkg::ERR_OK;
          res_dist <= accumulator;
          state    <= S_OUT;
          case (mode_q)
            vda_pkg::MODE_FASTL2: begin
              if (norms_small) begin
                res_err  <= vda_pkg::ERR_ZERO;
                res_dist <= '0;
              end else begin
                res_dist <= fast_sat;
                if (fast_ovf) begin
                  res_err <= vda_pkg::ERR_OVF;
                end
              end
            end
            vda_pkg::MODE_COS: begin
              if (norms_small) begin
                res_err  <= vda_pkg::ERR_ZERO;
                res_dist <= '0;
              end else begin
                state <= S_MUL;
              end
            end
            vda_pkg::MODE_NORMSQ: begin
              if (mag_acc < {32'd0, zero_threshold}) begin
                res_err  <= vda_pkg::ERR_ZERO;
                res_dist <= '0;
              end
            end
            vda_pkg::MODE_ROOT: begin
              state <= S_ROOT;
            end
            default: ;
          endcase
        end
        S_MUL: begin
          if (!unit_busy) begin
            if (unit_res == '0) begin
              // Zero denominator: report the divide by zero as overflow.
              res_err  <= vda_pkg::ERR_OVF;
              res_dist <= '0;
              state    <= S_OUT;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (!unit_busy) begin
            res_dist <= cos_sat;
            if (cos_ovf) begin
              res_err <= vda_pkg::ERR_OVF;
            end
            state <= S_OUT;
          end
        end
        S_ROOT: begin
          if (!unit_busy) begin
            if (unit_res < {80'd0, zero_threshold}) begin
              res_err  <= vda_pkg::ERR_ZERO;
              res_dist <= '0;
            end else begin
              res_dist <= unit_res[47:0];
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            distance      <= res_dist;
            error_code    <= res_err;
            accumulator   <= '0;
            overflow_seen <= 1'b0;
            elem_count    <= '0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_stall_when_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("element request taken while a result is in progress");
  a_zero_clears_dist: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code == vda_pkg::ERR_ZERO) |-> (distance == '0))
    else $error("zero vector result with nonzero distance");
  a_err_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (error_code != 2'd3))
    else $error("undefined error code");
  a_unit_idle_in_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !unit_busy)
    else $error("iterative unit busy while idle");
`endif

endmodule
`default_nettype wire

[sv/vda_iter_unit.sv]
// Iterative shared arithmetic unit: shift-add multiply, restoring divide and
// digit-by-digit square root, all on one 98-bit add/subtract. Uses vda_pkg.
`default_nettype none
module vda_iter_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire vda_pkg::unit_req_t   req,
  input  wire logic [95:0]          arg_a,
  input  wire logic [95:0]          arg_b,
  output logic                      busy,
  output logic [95:0]               result
);

  logic [97:0]      wa;
  logic [95:0]      wb;
  logic [95:0]      wc;
  logic [6:0]       cnt;
  logic [6:0]       steps;
  vda_pkg::uop_t    op;

  logic [97:0] opa;
  logic [97:0] opb;
  logic        sub;
  logic [98:0] sum;
  logic        no_borrow;

  always_comb begin
    opa = {2'b00, wa[95:0]};
    opb = {2'b00, wb};
    sub = 1'b0;
    unique case (op)
      vda_pkg::UOP_MUL: begin
        opa = wa;
        opb = {2'b00, wb};
        sub = 1'b0;
      end
      vda_pkg::UOP_DIV: begin
        opa = {wa[96:0], wc[95]};
        opb = {2'b00, wb};
        sub = 1'b1;
      end
      vda_pkg::UOP_SQRT: begin
        opa = {wa[95:0], wc[71:70]};
        opb = {wb, 2'b01};
        sub = 1'b1;
      end
      default: begin
        opa = wa;
        sub = 1'b0;
      end
    endcase
    sum = {1'b0, opa} + (sub ? {1'b0, ~opb} : {1'b0, opb}) + {98'd0, sub};
    no_borrow = sum[98];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      op   <= vda_pkg::UOP_MUL;
    end else if (req.start && !busy) begin
      busy <= 1'b1;
      cnt  <= '0;
      op   <= req.op;
      wa   <= '0;
      unique case (req.op)
        vda_pkg::UOP_MUL: begin
          wb    <= arg_a;
          wc    <= arg_b;
          steps <= vda_pkg::MUL_STEPS;
        end
        vda_pkg::UOP_DIV: begin
          wb    <= arg_b;
          wc    <= arg_a;
          steps <= vda_pkg::DIV_STEPS;
        end
        default: begin
          wb    <= '0;
          wc    <= arg_a;
          steps <= vda_pkg::SQRT_STEPS;
        end
      endcase
    end else if (busy) begin
      cnt <= cnt + 7'd1;
      if (cnt == steps - 7'd1) begin
        busy <= 1'b0;
      end
      unique case (op)
        vda_pkg::UOP_MUL: begin
          if (wc[0]) begin
            wa <= sum[97:0];
          end
          wb <= {wb[94:0], 1'b0};
          wc <= {1'b0, wc[95:1]};
        end
        vda_pkg::UOP_DIV: begin
          wa <= no_borrow ? sum[97:0] : opa;
          wc <= {wc[94:0], no_borrow};
        end
        default: begin
          wa <= no_borrow ? sum[97:0] : opa;
          wb <= {wb[94:0], no_borrow};
          wc <= {wc[93:0], 2'b00};
        end
      endcase
    end
  end

  always_comb begin
    unique case (op)
      vda_pkg::UOP_MUL: result = wa[95:0];
      vda_pkg::UOP_DIV: result = wc;
      default:          result = wb;
    endcase
  end

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for vector_distance_accumulator_top: random and directed vectors,
// checked result by result against a built-in predictor. Depends on vda_pkg and the RTL top.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  localparam int MAX_DIM = 1024;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES = 400;
  localparam longint MAX48 = 64'sh7FFF_FFFF_FFFF;
  localparam longint MIN48 = -64'sh8000_0000_0000;

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [47:0] na;
    logic signed [47:0] nb;
    logic               last;
  } elem_req_t;

  typedef struct {
    logic signed [47:0] dval;
    logic [1:0]         err;
  } dist_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] elem_a = '0;
  logic signed [15:0] elem_b = '0;
  logic signed [47:0] norm_a = '0;
  logic signed [47:0] norm_b = '0;
  logic last_elem = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [47:0] distance;
  logic [1:0] error_code;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  vector_distance_accumulator_top #(.MAX_DIMENSION(MAX_DIM)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .elem_a(elem_a), .elem_b(elem_b), .norm_a(norm_a), .norm_b(norm_b),
    .last_elem(last_elem),
    .out_valid(out_valid), .out_stall(out_stall),
    .distance(distance), .error_code(error_code),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Element requests waiting to be offered, and distances still owed by the block.
  elem_req_t pending_elems[$];
  dist_res_t owed_distances[$];
  int errors = 0;
  bit idling_on = 1'b1;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  // Predictor state: its own copy of the sum, overflow flag, element count and the two registers.
  longint sum_acc;
  bit sum_ovf;
  int sum_count;
  logic [2:0] cur_mode;
  logic [15:0] cur_thresh;

  function automatic longint sat48(longint x, inout bit hit);
    if (x > MAX48) begin
      hit = 1'b1;
      return MAX48;
    end
    if (x < MIN48) begin
      hit = 1'b1;
      return MIN48;
    end
    return x;
  endfunction

  function automatic longint mag(longint x);
    return (x < 0) ? -x : x;
  endfunction

  // Folds one element pair into the sum; on the last pair, queues the owed distance.
  function automatic void fold_element(elem_req_t r);
    logic [2:0] m;
    longint a, b, na, nb, dval;
    bit e1, e2, neg;
    logic [127:0] num, den, quo, root, trial, v;
    m = (cur_mode > vda_pkg::MODE_ROOT) ? vda_pkg::MODE_L2SQ : cur_mode;
    a = r.a;
    b = r.b;
    na = r.na;
    nb = r.nb;
    dval = 0;
    e2 = 1'b0;
    if (sum_count < MAX_DIM) begin
      if (m == vda_pkg::MODE_L2SQ) sum_acc = sat48(sum_acc + (a - b) * (a - b), sum_ovf);
      else if (m <= vda_pkg::MODE_COS) sum_acc = sat48(sum_acc + a * b, sum_ovf);
      else sum_acc = sat48(sum_acc + a * a, sum_ovf);
      sum_count++;
    end else begin
      sum_ovf = 1'b1;
    end
    if (!r.last) return;
    e1 = sum_ovf;
    case (m)
      vda_pkg::MODE_L2SQ, vda_pkg::MODE_DOT: dval = sum_acc;
      vda_pkg::MODE_FASTL2: begin
        if (mag(na) < cur_thresh || mag(nb) < cur_thresh) e2 = 1'b1;
        else dval = sat48(-2 * sum_acc + na + nb, e1);
      end
      vda_pkg::MODE_COS: begin
        if (mag(na) < cur_thresh || mag(nb) < cur_thresh) begin
          e2 = 1'b1;
        end else begin
          den = 128'(mag(na)) * 128'(mag(nb));
          if (den == 0) begin
            e1 = 1'b1;
          end else begin
            // Ratio in Q48: |sum| * 2^48 / (|na|*|nb|), clamped at 2^48.
            neg = (sum_acc < 0) != ((na < 0) != (nb < 0));
            num = 128'(mag(sum_acc)) << 48;
            quo = num / den;
            if (quo > (128'd1 << 48)) quo = 128'd1 << 48;
            dval = neg ? (64'sd1 << 24) + longint'(quo[63:0])
                       : (64'sd1 << 24) - longint'(quo[63:0]);
            dval = sat48(dval, e1);
          end
        end
      end
      vda_pkg::MODE_NORMSQ: begin
        if (mag(sum_acc) < cur_thresh) e2 = 1'b1;
        else dval = sum_acc;
      end
      default: begin
        v = 128'((sum_acc < 0) ? 0 : sum_acc) << 24;
        root = '0;
        for (int i = 35; i >= 0; i--) begin
          trial = root | (128'd1 << i);
          if (trial * trial <= v) root = trial;
        end
        if (root < cur_thresh) e2 = 1'b1;
        else dval = longint'(root[63:0]);
      end
    endcase
    if (e2) dval = 0;
    owed_distances.push_back('{dval: dval[47:0],
                               err: e2 ? vda_pkg::ERR_ZERO
                                       : (e1 ? vda_pkg::ERR_OVF : vda_pkg::ERR_OK)});
    sum_acc = 0;
    sum_ovf = 1'b0;
    sum_count = 0;
  endfunction

  // Driver: offers the head of the pending queue, with random gaps while idling is on, and holds it
  // steady until the block takes it. The predictor runs on every accepted request.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        fold_element(pending_elems.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (pending_elems.size() != 0 && !(idling_on && $urandom_range(0, 99) < 35)) begin
          in_valid <= 1'b1;
          elem_a <= pending_elems[0].a;
          elem_b <= pending_elems[0].b;
          norm_a <= pending_elems[0].na;
          norm_b <= pending_elems[0].nb;
          last_elem <= pending_elems[0].last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up and
  // has to stall its element channel.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= idling_on && ($urandom_range(0, 99) < 35);
    end
  end

  // Monitor: every accepted result is matched against the oldest owed distance.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (owed_distances.size() == 0) begin
        $error("unexpected result: distance %0d error_code %0d", distance, error_code);
        errors++;
      end else begin
        dist_res_t e;
        e = owed_distances.pop_front();
        if (distance !== e.dval) begin
          $error("distance: expected %0d, actual %0d", e.dval, distance);
          errors++;
        end
        if (error_code !== e.err) begin
          $error("error_code: expected %0d, actual %0d", e.err, error_code);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no request moves on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Waits until every request is taken and every result is back, then lets the
  // longest final step (cosine) run out in case the block is still busy.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_elems.size() != 0 || in_valid || owed_distances.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Holds the write until an edge accepts it, then drops it and waits with the
  // channel idle so that back-to-back writes never collide in one time step.
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    if (idx == vda_pkg::REG_MODE) cur_mode = val[2:0];
    else cur_thresh = val;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_elem();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // Norms span the zero-vector threshold, realistic Q24 magnitudes and the extremes.
  function automatic logic signed [47:0] pick_norm();
    logic signed [47:0] n;
    case ($urandom_range(0, 5))
      0: n = 48'($urandom_range(0, 70000));
      1: n = 48'($urandom_range(1 << 20, 1 << 30));
      2: n = 48'({$urandom, $urandom});
      3: n = $urandom_range(0, 1) ? 48'sh7FFF_FFFF_FFFF : 48'sh8000_0000_0000;
      default: n = 48'({$urandom_range(0, 255), $urandom});
    endcase
    if ($urandom_range(0, 3) == 0) n = -n;
    return n;
  endfunction

  function automatic void push_elem(logic signed [15:0] a, logic signed [15:0] b,
                                    logic signed [47:0] na, logic signed [47:0] nb,
                                    logic last);
    pending_elems.push_back('{a: a, b: b, na: na, nb: nb, last: last});
  endfunction

  task automatic push_vector(int len);
    for (int i = 0; i < len; i++) begin
      push_elem(pick_elem(), pick_elem(), pick_norm(), pick_norm(), i == len - 1);
    end
  endtask

  initial begin
    int sent;
    int len;
    logic [15:0] thr;
    sum_acc = 0;
    sum_ovf = 1'b0;
    sum_count = 0;
    cur_mode = vda_pkg::MODE_L2SQ;
    cur_thresh = vda_pkg::THRESH_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at reset settings: extreme elements, then a vector one element
    // longer than the dimension limit, which must flag overflow.
    push_elem(16'sh7FFF, 16'sh8000, '0, '0, 1'b1);
    push_elem(16'sh8000, 16'sh8000, '0, '0, 1'b0);
    push_elem(16'sh8000, 16'sh7FFF, '0, '0, 1'b1);
    for (int i = 0; i <= MAX_DIM; i++) push_elem(16'sh7FFF, 16'sh8000, '0, '0, i == MAX_DIM);
    wait_idle();
    // Fast L2 saturating high and low, and a zero norm.
    write_reg(vda_pkg::REG_MODE, 16'(vda_pkg::MODE_FASTL2));
    push_elem(16'sh8000, 16'sh7FFF, 48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF, 1'b1);
    push_elem(16'sh7FFF, 16'sh7FFF, 48'sh8000_0000_0000, 48'sh8000_0000_0000, 1'b1);
    push_elem(16'sh1000, 16'sh1000, 48'sd0, 48'sd1 << 24, 1'b1);
    wait_idle();
    // Cosine with a zero norm and threshold zero divides by zero; then normal cases.
    write_reg(vda_pkg::REG_MODE, 16'(vda_pkg::MODE_COS));
    write_reg(vda_pkg::REG_THRESH, 16'd0);
    push_elem(16'sh1000, 16'sh1000, 48'sd0, 48'sd1 << 24, 1'b1);
    push_elem(16'sh1000, 16'sh1000, 48'sd1 << 24, 48'sd1 << 24, 1'b1);
    push_elem(16'sh7FFF, 16'sh8000, 48'sd1, -48'sd1, 1'b1);
    push_elem(16'sh1000, 16'shF000, 48'sd1 << 24, 48'sd1 << 24, 1'b1);
    wait_idle();
    // Norm modes with the largest threshold: small sums fall to zero vector.
    write_reg(vda_pkg::REG_THRESH, 16'hFFFF);
    write_reg(vda_pkg::REG_MODE, 16'(vda_pkg::MODE_NORMSQ));
    push_elem(16'sh0001, 16'sh0, '0, '0, 1'b1);
    push_elem(16'sh7FFF, 16'sh0, '0, '0, 1'b1);
    wait_idle();
    write_reg(vda_pkg::REG_MODE, 16'(vda_pkg::MODE_ROOT));
    push_elem(16'sh0001, 16'sh0, '0, '0, 1'b1);
    push_elem(16'sh8000, 16'sh0, '0, '0, 1'b1);
    wait_idle();

    // Random part: every mode code, including the two unused ones, across thresholds.
    sent = 0;
    for (int ph = 0; sent < 800; ph++) begin
      case (ph % 5)
        0: thr = 16'd0;
        1: thr = 16'hFFFF;
        2: thr = vda_pkg::THRESH_RESET;
        3: thr = 16'($urandom_range(0, 3000));
        default: thr = 16'($urandom);
      endcase
      write_reg(vda_pkg::REG_MODE, 16'(ph % 8));
      write_reg(vda_pkg::REG_THRESH, thr);
      idling_on = (ph != 3);
      if (ph == 5) hold_go = 1'b1;
      for (int k = 0; k < 100; k += len) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
        push_vector(len);
      end
      sent += 100;
      wait_idle();
    end
    idling_on = 1'b1;

    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
